// ===== design/gbma_pkg.sv =====
`timescale 1ns / 1ps

package gbma_pkg;

  localparam int unsigned ADDR_W        = 16;
  localparam int unsigned RAW_ADDR_W    = 17;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned BOUND_W       = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned ADDRESS_SPACE = 65536;

  // request kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 1'b1;

  localparam logic [BOUND_W-1:0] LOWER_BOUND_RST = 16'h0800;
  localparam logic [BOUND_W-1:0] UPPER_BOUND_RST = 16'hC000;

  // fixed system locations
  localparam logic [ADDR_W-1:0] ADDR_KEYBOARD     = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_KBD_STROBE   = 16'hC010;
  localparam logic [ADDR_W-1:0] ADDR_SWITCH_LO    = 16'hC050;
  localparam logic [ADDR_W-1:0] ADDR_SWITCH_HI    = 16'hC05F;
  localparam logic [ADDR_W-1:0] ADDR_ZERO_READ_LO = 16'hC061;
  localparam logic [ADDR_W-1:0] ADDR_ZERO_READ_HI = 16'hC063;
  localparam logic [ADDR_W-1:0] ADDR_GFX_PAGE1    = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_GFX_PAGE2    = 16'h6000;

  // locations that skip the bounds check for reads and writes
  function automatic logic is_system(input logic [ADDR_W-1:0] a);
    logic hit;
    hit = 1'b0;
    if (a >= 16'h0020 && a <= 16'h0025) hit = 1'b1;
    if (a == 16'h0067 || a == 16'h0068 || a == 16'h0069 || a == 16'h006A) hit = 1'b1;
    if (a == 16'h0073 || a == 16'h0074) hit = 1'b1;
    if (a == 16'h00D8 || a == 16'h00DA || a == 16'h00DB || a == 16'h00DE) hit = 1'b1;
    if (a == 16'h00E8 || a == 16'h00E9) hit = 1'b1;
    if (a == ADDR_GFX_PAGE1 || a == ADDR_GFX_PAGE2) hit = 1'b1;
    if (a >= ADDR_SWITCH_LO && a <= ADDR_SWITCH_HI) hit = 1'b1;
    return hit;
  endfunction

endpackage

// ===== design/gbma_if.sv =====
`timescale 1ns / 1ps

interface gbma_req_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [gbma_pkg::RAW_ADDR_W-1:0] address;
  logic        [gbma_pkg::DATA_W-1:0]  write_value;

  modport source (output valid, mode, address, write_value, input ready);
  modport sink   (input valid, mode, address, write_value, output ready);
endinterface

interface gbma_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gbma_pkg::DATA_W-1:0]   read_data;
  logic                          range_error;

  modport source (output valid, read_data, range_error, input ready);
  modport sink   (input valid, read_data, range_error, output ready);
endinterface

interface gbma_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gbma_pkg::CFG_IDX_W-1:0]   index;
  logic [gbma_pkg::BOUND_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/guarded_byte_memory_access.sv =====
// path: an accepted request passes the request stage (s1), then the result register,
//   before its result shows on rsp; a stalled result side can hold it in s1
// throughput: one request per cycle while the result side keeps taking results
// the single-port byte memory (one read or write per cycle) sets that rate
// reset: bounds return to 0x0800 / 0xC000 and a clearing pass writes zero to every
//   byte, one per cycle; no request is taken during it,
//   configuration writes are taken throughout
`timescale 1ns / 1ps

module guarded_byte_memory_access #(
  parameter int unsigned ADDRESS_SPACE = gbma_pkg::ADDRESS_SPACE
) (
  input  logic          clk,
  input  logic          rst,
  gbma_req_if.sink      req,
  gbma_rsp_if.source    rsp,
  gbma_cfg_if.sink      cfg
);

  localparam int unsigned AW      = $clog2(ADDRESS_SPACE);
  localparam int unsigned REM_W   = gbma_pkg::ADDR_W + 8;
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned PROD_W  = gbma_pkg::ADDR_W + RECIP_W - 1;
  // 2^32 / ADDRESS_SPACE rounded up; at most 2^24 for a 256-byte store
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << 32) + 64'(ADDRESS_SPACE) - 64'd1) / 64'(ADDRESS_SPACE));

  // bound registers
  logic [gbma_pkg::BOUND_W-1:0] lower_bound;
  logic [gbma_pkg::BOUND_W-1:0] upper_bound;

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // byte store and its registered read port
  logic [gbma_pkg::DATA_W-1:0] mem [ADDRESS_SPACE];
  logic [gbma_pkg::DATA_W-1:0] mem_q;

  // request stage: waits for the memory read data
  logic s1_valid;
  logic s1_use_mem;
  logic s1_err;

  // result register
  logic                        out_valid;
  logic [gbma_pkg::DATA_W-1:0] out_data;
  logic                        out_err;

  logic                        req_fire;
  logic                        s1_move;
  logic [gbma_pkg::ADDR_W-1:0] addr;
  logic                        sys_hit;
  logic                        in_range;
  logic                        allowed;
  logic                        do_write;
  logic                        do_read;
  logic                        req_err;
  logic [PROD_W-1:0]           prod;
  logic [7:0]                  quo;
  logic [REM_W-1:0]            rem;
  logic [AW-1:0]               slot;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [gbma_pkg::DATA_W-1:0] mem_wdata;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= gbma_pkg::LOWER_BOUND_RST;
      upper_bound <= gbma_pkg::UPPER_BOUND_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gbma_pkg::CFG_LOWER_BOUND: lower_bound <= cfg.data;
        gbma_pkg::CFG_UPPER_BOUND: upper_bound <= cfg.data;
        default: ;
      endcase
    end
  end

  // a negative 17-bit address plus 65536 is just its low 16 bits
  assign addr     = req.address[gbma_pkg::ADDR_W-1:0];
  assign sys_hit  = gbma_pkg::is_system(addr);
  assign in_range = (addr >= lower_bound) && (addr <= upper_bound);
  assign allowed  = sys_hit || in_range;

  // handshake: the stage frees up either empty or moving on this cycle
  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || s1_move);
  assign req_fire  = req.valid && req.ready;

  // decode what this request does
  always_comb begin
    do_write = 1'b0;
    do_read  = 1'b0;
    req_err  = 1'b0;
    if (req.mode == gbma_pkg::MODE_WRITE) begin
      if (addr == gbma_pkg::ADDR_KBD_STROBE) begin
        // strobe write is dropped silently
      end else if (allowed) begin
        do_write = 1'b1;
      end else begin
        req_err = 1'b1;
      end
    end else begin
      if (addr == gbma_pkg::ADDR_KEYBOARD) begin
        do_read = 1'b1;
      end else if (addr >= gbma_pkg::ADDR_ZERO_READ_LO && addr <= gbma_pkg::ADDR_ZERO_READ_HI) begin
        // these read back as zero
      end else if (allowed) begin
        do_read = 1'b1;
      end else begin
        req_err = 1'b1;
      end
    end
  end

  // store slot: address modulo ADDRESS_SPACE by reciprocal multiplication; the
  // quotient fits in 8 bits since the store holds at least 256 bytes, and the
  // rounded-up reciprocal keeps it exact for every 16-bit address
  assign prod = PROD_W'(addr) * PROD_W'(RECIP);
  assign quo  = prod[PROD_W-1:32];
  assign rem  = REM_W'(addr) - REM_W'(quo) * REM_W'(ADDRESS_SPACE);
  assign slot = rem[AW-1:0];

  // single write port shared by the clearing pass and requests
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = req_fire && do_write;
      mem_waddr = slot;
      mem_wdata = req.write_value;
    end
  end

  // a write lands at the accept edge, so a read accepted after it
  // already sees it: no forwarding path is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_fire && do_read) begin
      mem_q <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(ADDRESS_SPACE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // request stage; mem_q only changes on a new accept, which needs this stage to move
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (req_fire) begin
      s1_use_mem <= do_read;
      s1_err     <= req_err;
    end
  end

  // result register; writes, errors and the zero-read switches give zero data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      out_data <= s1_use_mem ? mem_q : '0;
      out_err  <= s1_err;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = out_data;
  assign rsp.range_error = out_err;

endmodule

// ===== design/gbma_chk.sv =====
`timescale 1ns / 1ps

module gbma_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [gbma_pkg::DATA_W-1:0] rsp_read_data,
  input logic                        rsp_range_error
);

  // an error result never carries data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_range_error |-> rsp_read_data == '0)
    else $error("range error result with nonzero data");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_range_error))
    else $error("stalled result changed");

  // the clearing pass blocks requests right after reset
  a_clear_block: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during clearing pass");

  // a request taken with the result side empty shows a result once it has passed s1 and the result register
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid)
    else $error("result missing after accepted request");

endmodule

bind guarded_byte_memory_access gbma_chk u_gbma_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_read_data   (rsp.read_data),
  .rsp_range_error (rsp.range_error)
);

// ===== tb/gbma_checker.sv =====
`timescale 1ns / 1ps

module gbma_checker #(
  parameter int unsigned ADDRESS_SPACE = gbma_pkg::ADDRESS_SPACE
) (
  input  logic clk,
  input  logic rst,
  gbma_req_if  req,
  gbma_rsp_if  rsp,
  gbma_cfg_if  cfg,
  output int   mismatches,
  output int   pending
);

  import gbma_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              range_error;
  } access_result_t;

  logic [DATA_W-1:0]  shadow_mem [ADDRESS_SPACE];
  logic [BOUND_W-1:0] floor_addr;
  logic [BOUND_W-1:0] ceil_addr;
  access_result_t     expected_results [$];
  int                 err_count;

  // zero page, graphics pages and soft switches
  function automatic bit bypasses_bounds(input logic [ADDR_W-1:0] a);
    case (a)
      16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025,
      16'h0067, 16'h0068, 16'h0069, 16'h006A, 16'h0073, 16'h0074,
      16'h00D8, 16'h00DA, 16'h00DB, 16'h00DE, 16'h00E8, 16'h00E9,
      ADDR_GFX_PAGE1, ADDR_GFX_PAGE2: return 1'b1;
      default: return (a >= ADDR_SWITCH_LO) && (a <= ADDR_SWITCH_HI);
    endcase
  endfunction

  function automatic access_result_t apply_access(input logic m,
                                                  input logic [RAW_ADDR_W-1:0] raw,
                                                  input logic [DATA_W-1:0] wv);
    logic [ADDR_W-1:0] a;
    int unsigned       slot;
    bit                allowed;
    access_result_t    res;
    // negative addresses wrap to the low 16 bits
    a       = raw[ADDR_W-1:0];
    slot    = a % ADDRESS_SPACE;
    allowed = bypasses_bounds(a) || ((a >= floor_addr) && (a <= ceil_addr));
    res     = '0;
    if (m == MODE_WRITE) begin
      if (a == ADDR_KBD_STROBE) begin
        // strobe write is dropped silently
      end else if (allowed) begin
        shadow_mem[slot] = wv;
      end else begin
        res.range_error = 1'b1;
      end
    end else begin
      if (a == ADDR_KEYBOARD) begin
        res.read_data = shadow_mem[slot];
      end else if ((a >= ADDR_ZERO_READ_LO) && (a <= ADDR_ZERO_READ_HI)) begin
        res.read_data = '0;
      end else if (allowed) begin
        res.read_data = shadow_mem[slot];
      end else begin
        res.range_error = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    int k;
    if (rst) begin
      for (k = 0; k < ADDRESS_SPACE; k++) shadow_mem[k] = '0;
      floor_addr = LOWER_BOUND_RST;
      ceil_addr  = UPPER_BOUND_RST;
      expected_results.delete();
      err_count  = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_LOWER_BOUND) floor_addr = cfg.data;
        else ceil_addr = cfg.data;
      end
      // results first, so a request taken at this edge never matches them
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_data=%02h range_error=%b",
                   $time, rsp.read_data, rsp.range_error);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.read_data !== want.read_data) begin
            $display("%0t: read_data expected %02h actual %02h",
                     $time, want.read_data, rsp.read_data);
            err_count++;
          end
          if (rsp.range_error !== want.range_error) begin
            $display("%0t: range_error expected %b actual %b",
                     $time, want.range_error, rsp.range_error);
            err_count++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(apply_access(req.mode, req.address, req.write_value));
    end
    mismatches <= err_count;
    pending    <= expected_results.size();
  end

endmodule

// ===== tb/guarded_byte_memory_access_test.sv =====
`timescale 1ns / 1ps

module guarded_byte_memory_access_test;

  import gbma_pkg::*;

  // no request is taken during the clearing pass after reset, which the limit outlasts
  localparam int QUIET_LIMIT = 4 * ADDRESS_SPACE + 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gbma_req_if req ();
  gbma_rsp_if rsp ();
  gbma_cfg_if cfg ();

  int mismatches;
  int pending;

  guarded_byte_memory_access #(.ADDRESS_SPACE(ADDRESS_SPACE)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  gbma_checker #(.ADDRESS_SPACE(ADDRESS_SPACE)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bounds as last written, used to aim addresses at the edges
  logic [BOUND_W-1:0] bound_lo = LOWER_BOUND_RST;
  logic [BOUND_W-1:0] bound_hi = UPPER_BOUND_RST;

  // small per-phase set of working addresses so reads find earlier writes
  logic [ADDR_W-1:0] hot_addr [12];
  // fixed system locations and their neighbors
  logic [ADDR_W-1:0] landmark [36];

  // no idling on either side while set; the receiver then makes one long hold
  logic calm = 1'b0;

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, plus one long hold during the calm stretch
  // ---------------------------------------------------------------------------
  int hold_left;
  int results_taken;
  bit held_once;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready     <= 1'b0;
      hold_left     <= 0;
      results_taken <= 0;
      held_once     <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) results_taken <= results_taken + 1;
      if (hold_left != 0) begin
        // receiver holds off, the block fills and stalls its request side
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else if (calm && !held_once && results_taken >= 60) begin
        held_once <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no handshake on any channel
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request and hold it until the block takes it
  task automatic send(input logic m, input logic [RAW_ADDR_W-1:0] a,
                      input logic [DATA_W-1:0] v);
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req.valid       <= 1'b1;
    req.mode        <= m;
    req.address     <= a;
    req.write_value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // leave slack before touching the bounds
    repeat (4) @(posedge clk);
  endtask

  // write both bound registers back to back, only while idle
  task automatic set_bounds(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_LOWER_BOUND;
    cfg.data  <= lo;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.index <= CFG_UPPER_BOUND;
    cfg.data  <= hi;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    bound_lo = lo;
    bound_hi = hi;
  endtask

  function automatic logic [RAW_ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    int                r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      a = hot_addr[$urandom_range(0, 11)];
    end else if (r < 62) begin
      a = landmark[$urandom_range(0, 35)];
    end else if (r < 76) begin
      case ($urandom_range(0, 3))
        0:       a = bound_lo - 1'b1;
        1:       a = bound_lo;
        2:       a = bound_hi;
        default: a = bound_hi + 1'b1;
      endcase
    end else begin
      a = ADDR_W'($urandom());
    end
    // top bit set gives the same location as a negative address
    return {1'($urandom_range(0, 1)), a};
  endfunction

  task automatic run_random(input int count);
    foreach (hot_addr[k]) begin
      if (k < 8 && bound_lo <= bound_hi)
        hot_addr[k] = ADDR_W'($urandom_range(bound_lo, bound_hi));
      else
        hot_addr[k] = ADDR_W'($urandom());
    end
    repeat (count) begin
      send(1'($urandom_range(0, 1)), pick_address(), DATA_W'($urandom_range(0, 255)));
    end
    drain();
  endtask

  initial begin
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;

    req.valid       = 1'b0;
    req.mode        = MODE_READ;
    req.address     = '0;
    req.write_value = '0;
    cfg.valid       = 1'b0;
    cfg.index       = CFG_LOWER_BOUND;
    cfg.data        = '0;
    rsp.ready       = 1'b0;

    landmark = '{16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025,
                 16'h0067, 16'h0068, 16'h0069, 16'h006A, 16'h0073, 16'h0074,
                 16'h00D8, 16'h00DA, 16'h00DB, 16'h00DE, 16'h00E8, 16'h00E9,
                 ADDR_GFX_PAGE1, ADDR_GFX_PAGE2, ADDR_SWITCH_LO, 16'hC057,
                 ADDR_SWITCH_HI, ADDR_KEYBOARD, ADDR_KBD_STROBE, ADDR_ZERO_READ_LO,
                 16'hC062, ADDR_ZERO_READ_HI, 16'hC04F, 16'hC060, 16'hC064,
                 16'h001F, 16'h0026, 16'h00D9, 16'h0000, 16'hFFFF};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset bounds 0x0800..0xC000;
    // the first request waits out the clearing pass
    send(MODE_READ,  17'sh00800, 8'h00);   // cleared store reads zero
    send(MODE_WRITE, 17'sh00800, 8'hFF);   // lowest ordinary address
    send(MODE_READ,  17'sh00800, 8'h00);   // read right behind the write
    send(MODE_WRITE, 17'sh0C000, 8'hA5);   // highest ordinary address
    send(MODE_READ,  -17'sd16384, 8'h00);  // same location via a negative address
    send(MODE_WRITE, -17'sd65536, 8'h12);  // most negative address, below bounds
    send(MODE_READ,  17'sd65535, 8'h00);   // top of memory, out of bounds
    send(MODE_READ,  -17'sd1, 8'h00);      // same location, negative form
    send(MODE_WRITE, 17'sh00020, 8'h5A);   // zero page skips the check
    send(MODE_READ,  17'sh00020, 8'h00);
    send(MODE_WRITE, 17'sh000E9, 8'h01);
    send(MODE_READ,  17'sh000E9, 8'h00);
    send(MODE_WRITE, 17'sh04000, 8'h40);   // graphics page bases
    send(MODE_READ,  17'sh06000, 8'h00);
    send(MODE_WRITE, 17'sh0C05F, 8'h77);   // switch above the upper bound
    send(MODE_READ,  17'sh0C05F, 8'h00);
    send(MODE_WRITE, 17'sh0C010, 8'h33);   // strobe write is dropped, no error
    send(MODE_READ,  17'sh0C010, 8'h00);   // but reading it is bounds checked
    send(MODE_READ,  17'sh0C061, 8'h00);   // fixed-zero reads
    send(MODE_READ,  17'sh0C063, 8'h00);
    send(MODE_READ,  17'sh0C060, 8'h00);   // neighbors of the fixed-zero range
    send(MODE_READ,  17'sh0C064, 8'h00);
    send(MODE_WRITE, 17'sh007FF, 8'h99);   // just below the lower bound
    send(MODE_WRITE, 17'sh0C001, 8'h99);   // just above the upper bound
    send(MODE_WRITE, 17'sh0BFFF, 8'h00);
    drain();

    // whole range open, both sides steady while the receiver holds off once
    set_bounds(16'h0000, 16'hFFFF);
    calm <= 1'b1;
    run_random(160);
    calm <= 1'b0;
    run_random(60);

    // crossed bounds: only system locations and the keyboard, strobe and zero-read cases pass
    set_bounds(16'hFFFF, 16'h0000);
    run_random(80);

    // random ordered bounds
    repeat (3) begin
      lo = BOUND_W'($urandom());
      hi = BOUND_W'($urandom());
      if (lo > hi) set_bounds(hi, lo);
      else set_bounds(lo, hi);
      run_random(70);
    end

    // a single allowed location
    lo = BOUND_W'($urandom());
    set_bounds(lo, lo);
    run_random(60);

    // back to the power-on window
    set_bounds(LOWER_BOUND_RST, UPPER_BOUND_RST);
    run_random(60);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gbma_pkg.sv
design/gbma_if.sv
design/guarded_byte_memory_access.sv
design/gbma_chk.sv
tb/gbma_checker.sv
tb/guarded_byte_memory_access_test.sv
